>>> rtl/single_rate_three_color_meter_assert.svh
// Assertion macros shared by the meter's checker.
`ifndef SINGLE_RATE_THREE_COLOR_METER_ASSERT_SVH
`define SINGLE_RATE_THREE_COLOR_METER_ASSERT_SVH

// Property that must hold in every cycle out of reset.
`define SRTCM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition in one cycle implies a condition in the next cycle.
`define SRTCM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) ante |=> cons) \
    else $error(msg);

`endif

>>> rtl/srtcm_pkg.sv
// Types and constants of the single-rate three-color meter.
package srtcm_pkg;

  localparam int TOKEN_W    = 32;
  localparam int TIME_W     = 48;
  localparam int RATE_W     = 40;
  localparam int BITS_W     = 20;
  localparam int COLOR_W    = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 40;

  typedef enum logic [COLOR_W-1:0] {
    COLOR_GREEN  = 2'd0,
    COLOR_YELLOW = 2'd1,
    COLOR_RED    = 2'd2
  } color_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CIR_RATE    = 2'd0,
    REG_CBS         = 2'd1,
    REG_EBS         = 2'd2,
    REG_COLOR_AWARE = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [TIME_W-1:0]  arrival_time;
    logic [BITS_W-1:0]  packet_bits;
    logic [COLOR_W-1:0] in_color;
  } in_word_t;

  typedef struct packed {
    color_e             out_color;
    logic [TOKEN_W-1:0] committed_level;
    logic [TOKEN_W-1:0] excess_level;
  } out_word_t;

  // Classified packet handed from front to back.
  typedef struct packed {
    logic [TOKEN_W-1:0] add_tokens;
    logic [BITS_W-1:0]  packet_bits;
    logic [COLOR_W-1:0] color;
  } mid_word_t;

  typedef struct packed {
    logic [RATE_W-1:0]  cir_rate;
    logic [TOKEN_W-1:0] committed_burst;
    logic [TOKEN_W-1:0] excess_burst;
    logic               color_aware;
  } cfg_t;

  // Bucket refill on a burst write.
  typedef struct packed {
    logic               load_committed;
    logic               load_excess;
    logic [TOKEN_W-1:0] value;
  } cfg_load_t;

endpackage

>>> rtl/srtcm_fifo.sv
// Small register queue used between the meter's stages.
module srtcm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> rtl/srtcm_front.sv
// Front pipeline: elapsed time, token refill product and color resolution.
module srtcm_front #(
  parameter int RATE_FRAC_BITS = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  srtcm_pkg::in_word_t  in_word_i,
  output logic                 full_o,
  input  srtcm_pkg::cfg_t      cfg_i,
  input  logic                 mid_full_i,
  output logic                 mid_push_o,
  output srtcm_pkg::mid_word_t mid_word_o
);
  import srtcm_pkg::*;

  localparam int PROD_W = TIME_W + RATE_W;
  localparam int E_LO_W = TIME_W / 2;
  localparam int E_HI_W = TIME_W - E_LO_W;
  localparam int R_LO_W = RATE_W / 2;
  localparam int R_HI_W = RATE_W - R_LO_W;

  logic advance, accept;

  // stage 1
  logic                v1_q;
  logic [TIME_W-1:0]   last_q;
  logic [TIME_W-1:0]   elapsed_q;
  logic [BITS_W-1:0]   bits1_q;
  logic [COLOR_W-1:0]  color1_q;
  // stage 2
  logic                       v2_q;
  logic [E_LO_W+R_LO_W-1:0]   pp_ll_q;
  logic [E_LO_W+R_HI_W-1:0]   pp_lh_q;
  logic [E_HI_W+R_LO_W-1:0]   pp_hl_q;
  logic [E_HI_W+R_HI_W-1:0]   pp_hh_q;
  logic [BITS_W-1:0]          bits2_q;
  logic [COLOR_W-1:0]         color2_q;
  // stage 3
  logic                v3_q;
  logic [TOKEN_W-1:0]  add3_q;
  logic [BITS_W-1:0]   bits3_q;
  logic [COLOR_W-1:0]  color3_q;

  logic [PROD_W-1:0]   product, scaled;
  logic [TOKEN_W-1:0]  add_d;
  logic [COLOR_W-1:0]  color_d;

  // whole pipeline holds while the last stage cannot hand off
  assign advance = !(v3_q && mid_full_i);
  assign full_o  = !advance;
  assign accept  = push_i && advance;

  assign color_d = cfg_i.color_aware ? in_word_i.in_color : COLOR_GREEN;

  assign product = PROD_W'(pp_ll_q)
                 + (PROD_W'(pp_lh_q) << R_LO_W)
                 + (PROD_W'(pp_hl_q) << E_LO_W)
                 + (PROD_W'(pp_hh_q) << (E_LO_W + R_LO_W));
  assign scaled  = product >> RATE_FRAC_BITS;
  assign add_d   = (|scaled[PROD_W-1:TOKEN_W]) ? '1 : scaled[TOKEN_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      last_q <= '0;
    end else if (advance) begin
      v1_q <= push_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (accept) begin
        last_q <= in_word_i.arrival_time;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      elapsed_q <= in_word_i.arrival_time - last_q;
      bits1_q   <= in_word_i.packet_bits;
      color1_q  <= color_d;

      pp_ll_q  <= elapsed_q[E_LO_W-1:0] * cfg_i.cir_rate[R_LO_W-1:0];
      pp_lh_q  <= elapsed_q[E_LO_W-1:0] * cfg_i.cir_rate[RATE_W-1:R_LO_W];
      pp_hl_q  <= elapsed_q[TIME_W-1:E_LO_W] * cfg_i.cir_rate[R_LO_W-1:0];
      pp_hh_q  <= elapsed_q[TIME_W-1:E_LO_W] * cfg_i.cir_rate[RATE_W-1:R_LO_W];
      bits2_q  <= bits1_q;
      color2_q <= color1_q;

      add3_q   <= add_d;
      bits3_q  <= bits2_q;
      color3_q <= color2_q;
    end
  end

  assign mid_push_o             = v3_q && !mid_full_i;
  assign mid_word_o.add_tokens  = add3_q;
  assign mid_word_o.packet_bits = bits3_q;
  assign mid_word_o.color       = color3_q;

endmodule

>>> rtl/srtcm_back.sv
// Back end: bucket refill, marking and charging, one packet per cycle unless a queue stalls.
module srtcm_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  srtcm_pkg::cfg_t      cfg_i,
  input  srtcm_pkg::cfg_load_t load_i,
  input  logic                 mid_empty_i,
  input  srtcm_pkg::mid_word_t mid_word_i,
  output logic                 mid_pop_o,
  input  logic                 out_full_i,
  output logic                 out_push_o,
  output srtcm_pkg::out_word_t out_word_o
);
  import srtcm_pkg::*;

  logic [TOKEN_W-1:0] c_q, c_d, e_q, e_d;
  logic [TOKEN_W:0]   sum, extra;
  logic [TOKEN_W+1:0] esum;
  logic [TOKEN_W-1:0] c_fill, e_fill;
  logic [TOKEN_W-1:0] bits;
  logic               fits, fire;
  color_e             mark;

  assign fire = !mid_empty_i && !out_full_i;
  assign bits = TOKEN_W'(mid_word_i.packet_bits);

  always_comb begin
    sum   = {1'b0, c_q} + {1'b0, mid_word_i.add_tokens};
    fits  = (sum <= {1'b0, cfg_i.committed_burst});
    extra = sum - {1'b0, cfg_i.committed_burst};
    esum  = {2'b00, e_q} + {1'b0, extra};
    if (fits) begin
      c_fill = sum[TOKEN_W-1:0];
      e_fill = e_q;
    end else begin
      c_fill = cfg_i.committed_burst;
      e_fill = (esum <= {2'b00, cfg_i.excess_burst}) ? esum[TOKEN_W-1:0]
                                                      : cfg_i.excess_burst;
    end

    c_d  = c_fill;
    e_d  = e_fill;
    mark = COLOR_RED;
    if (mid_word_i.color == COLOR_GREEN && c_fill >= bits) begin
      c_d  = c_fill - bits;
      mark = COLOR_GREEN;
    end else if ((mid_word_i.color == COLOR_GREEN || mid_word_i.color == COLOR_YELLOW)
                 && e_fill >= bits) begin
      e_d  = e_fill - bits;
      mark = COLOR_YELLOW;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q <= '0;
      e_q <= '0;
    end else begin
      if (load_i.load_committed) begin
        c_q <= load_i.value;
      end else if (fire) begin
        c_q <= c_d;
      end
      if (load_i.load_excess) begin
        e_q <= load_i.value;
      end else if (fire) begin
        e_q <= e_d;
      end
    end
  end

  assign mid_pop_o                  = fire;
  assign out_push_o                 = fire;
  assign out_word_o.out_color       = mark;
  assign out_word_o.committed_level = c_d;
  assign out_word_o.excess_level    = e_d;

endmodule

>>> rtl/single_rate_three_color_meter.sv
// Top level of the single-rate three-color packet meter.
//
// Usage:
//  - Packet words enter on push/full: a word is taken at a clock edge with
//    push high and full low. Each word carries arrival time, length in bits
//    and the incoming color.
//  - Results leave on empty/pop: the oldest result sits on out_word_o while
//    empty is low and is taken at an edge with pop high.
//  - Configuration: cfg_valid_i/cfg_ready_o with a register index and data.
//    cfg_ready_o is always high. Writing a burst size also fills its bucket.
//    Write only while the meter holds no packet in flight.
//  - Path: a packet passes the three front stages and the middle queue; the
//    bucket update then writes its result into the output queue.
//  - Throughput: one packet per cycle while no queue is full; the 48x40
//    refill product is split over two front stages.
//  - If pop stays low, results pile up in the output queue, then the middle
//    queue, then the front pipeline stops and full rises.
//  - Reset clears all configuration, both buckets and the last arrival time.
module single_rate_three_color_meter #(
  parameter int RATE_FRAC_BITS = 24,
  parameter int MID_DEPTH      = 4,
  parameter int OUT_DEPTH      = 2
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // packet words in
  input  logic                                 push,
  output logic                                 full,
  input  srtcm_pkg::in_word_t                  in_word_i,
  // result words out
  output logic                                 empty,
  input  logic                                 pop,
  output srtcm_pkg::out_word_t                 out_word_o,
  // configuration writes
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [srtcm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [srtcm_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import srtcm_pkg::*;

  cfg_t      cfg_q;
  cfg_load_t cfg_load;
  logic      cfg_we;

  logic      mid_push, mid_full, mid_pop, mid_empty;
  mid_word_t mid_in, mid_out;
  logic [$bits(mid_word_t)-1:0] mid_out_raw;

  logic      out_push, out_full;
  out_word_t back_word;
  logic [$bits(out_word_t)-1:0] out_raw;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // burst writes refill the matching bucket in the back end
  always_comb begin
    cfg_load.load_committed = 1'b0;
    cfg_load.load_excess    = 1'b0;
    cfg_load.value          = cfg_data_i[TOKEN_W-1:0];
    if (cfg_we) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_CBS: cfg_load.load_committed = 1'b1;
        REG_EBS: cfg_load.load_excess    = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_CIR_RATE:    cfg_q.cir_rate        <= cfg_data_i[RATE_W-1:0];
        REG_CBS:         cfg_q.committed_burst <= cfg_data_i[TOKEN_W-1:0];
        REG_EBS:         cfg_q.excess_burst    <= cfg_data_i[TOKEN_W-1:0];
        REG_COLOR_AWARE: cfg_q.color_aware     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  srtcm_front #(
    .RATE_FRAC_BITS(RATE_FRAC_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .in_word_i  (in_word_i),
    .full_o     (full),
    .cfg_i      (cfg_q),
    .mid_full_i (mid_full),
    .mid_push_o (mid_push),
    .mid_word_o (mid_in)
  );

  // decouples the refill pipeline from the bucket update
  srtcm_fifo #(
    .WIDTH($bits(mid_word_t)),
    .DEPTH(MID_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_in),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_out_raw),
    .empty_o (mid_empty)
  );

  assign mid_out = mid_word_t'(mid_out_raw);

  srtcm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .load_i      (cfg_load),
    .mid_empty_i (mid_empty),
    .mid_word_i  (mid_out),
    .mid_pop_o   (mid_pop),
    .out_full_i  (out_full),
    .out_push_o  (out_push),
    .out_word_o  (back_word)
  );

  // result queue toward the receiver
  srtcm_fifo #(
    .WIDTH($bits(out_word_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (back_word),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_raw),
    .empty_o (empty)
  );

  assign out_word_o = out_word_t'(out_raw);

endmodule

>>> rtl/srtcm_checker.sv
// Port-level checks of the meter, bound to its top level.
`include "single_rate_three_color_meter_assert.svh"

module srtcm_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             push,
  input logic                             full,
  input logic                             empty,
  input logic                             pop,
  input srtcm_pkg::out_word_t             out_word_o,
  input logic                             cfg_valid_i,
  input logic                             cfg_ready_o,
  input logic [srtcm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input logic [srtcm_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import srtcm_pkg::*;

  logic [7:0]         pending_q;
  logic [TOKEN_W-1:0] cbs_q, ebs_q;
  logic               in_take, out_take, cfg_take;
  logic               stalled, level_ok, color_ok;

  assign in_take  = push && !full;
  assign out_take = pop && !empty;
  assign cfg_take = cfg_valid_i && cfg_ready_o;
  assign stalled  = !empty && !pop;
  assign level_ok = (out_word_o.committed_level <= cbs_q)
                 && (out_word_o.excess_level <= ebs_q);
  assign color_ok = (out_word_o.out_color == COLOR_GREEN)
                 || (out_word_o.out_color == COLOR_YELLOW)
                 || (out_word_o.out_color == COLOR_RED);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
      cbs_q     <= '0;
      ebs_q     <= '0;
    end else begin
      pending_q <= pending_q + 8'(in_take) - 8'(out_take);
      if (cfg_take && cfg_index_i == REG_CBS) begin
        cbs_q <= cfg_data_i[TOKEN_W-1:0];
      end
      if (cfg_take && cfg_index_i == REG_EBS) begin
        ebs_q <= cfg_data_i[TOKEN_W-1:0];
      end
    end
  end

  `SRTCM_ASSERT_NEXT(a_stall_holds, stalled, (!empty && $stable(out_word_o)), "result moved in stall")
  `SRTCM_ASSERT(a_no_orphan, (!empty |-> pending_q != 8'd0), "result without a pending packet")
  `SRTCM_ASSERT(a_level_cap, (!empty |-> level_ok), "bucket level above burst size")
  `SRTCM_ASSERT(a_color_code, (!empty |-> color_ok), "illegal color code")

endmodule

bind single_rate_three_color_meter srtcm_checker u_checker (.*);

>>> sim/srtcm_meter_check_pkg.sv
// Bucket predictor and result scoreboard for the single-rate three-color meter bench.
package srtcm_meter_check_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  import srtcm_pkg::*;

  localparam int RATE_FRAC = 24;
  localparam int PRODUCT_W = TIME_W + RATE_W;

  class meter_scoreboard;
    logic [RATE_W-1:0]  cir_rate;
    logic [TOKEN_W-1:0] committed_burst;
    logic [TOKEN_W-1:0] excess_burst;
    logic               color_aware;
    logic [TOKEN_W-1:0] committed_tokens;
    logic [TOKEN_W-1:0] excess_tokens;
    logic [TIME_W-1:0]  last_arrival;
    out_word_t          expected_q[$];
    int unsigned        mismatches;

    function new();
      cir_rate         = '0;
      committed_burst  = '0;
      excess_burst     = '0;
      color_aware      = 1'b0;
      committed_tokens = '0;
      excess_tokens    = '0;
      last_arrival     = '0;
      mismatches       = 0;
    endfunction

    // burst writes refill their bucket to the new size
    function void write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_CIR_RATE: cir_rate = data[RATE_W-1:0];
        REG_CBS: begin
          committed_burst  = data[TOKEN_W-1:0];
          committed_tokens = committed_burst;
        end
        REG_EBS: begin
          excess_burst  = data[TOKEN_W-1:0];
          excess_tokens = excess_burst;
        end
        REG_COLOR_AWARE: color_aware = data[0];
        default: ;
      endcase
    endfunction

    function void note_packet(in_word_t pkt);
      logic [PRODUCT_W-1:0] refill_wide;
      logic [TOKEN_W-1:0]   refill;
      logic [TOKEN_W:0]     filled;
      logic [TOKEN_W+1:0]   excess_sum;
      logic [COLOR_W-1:0]   color;
      out_word_t            res;
      // elapsed ticks wrap at the timestamp width
      refill_wide = ({{RATE_W{1'b0}}, pkt.arrival_time - last_arrival}
                     * {{TIME_W{1'b0}}, cir_rate}) >> RATE_FRAC;
      refill = (refill_wide[PRODUCT_W-1:TOKEN_W] != '0) ? '1 : refill_wide[TOKEN_W-1:0];
      last_arrival = pkt.arrival_time;
      filled = {1'b0, committed_tokens} + refill;
      if (filled <= committed_burst) begin
        committed_tokens = filled[TOKEN_W-1:0];
      end else begin
        excess_sum       = excess_tokens + (filled - committed_burst);
        committed_tokens = committed_burst;
        excess_tokens    = (excess_sum <= excess_burst) ? excess_sum[TOKEN_W-1:0] : excess_burst;
      end
      color = color_aware ? pkt.in_color : COLOR_GREEN;
      if (color == COLOR_GREEN && committed_tokens >= pkt.packet_bits) begin
        committed_tokens -= pkt.packet_bits;
        res.out_color = COLOR_GREEN;
      end else if (color <= COLOR_YELLOW && excess_tokens >= pkt.packet_bits) begin
        excess_tokens -= pkt.packet_bits;
        res.out_color = COLOR_YELLOW;
      end else begin
        res.out_color = COLOR_RED;
      end
      res.committed_level = committed_tokens;
      res.excess_level    = excess_tokens;
      expected_q.push_back(res);
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%t: result word with nothing pending, color %0d committed %0d excess %0d",
                 $realtime, got.out_color, got.committed_level, got.excess_level);
        return;
      end
      want = expected_q.pop_front();
      compare_field("out_color", want.out_color, got.out_color);
      compare_field("committed_level", want.committed_level, got.committed_level);
      compare_field("excess_level", want.excess_level, got.excess_level);
    endfunction

    function void compare_field(string field, logic [TOKEN_W-1:0] want,
                                logic [TOKEN_W-1:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%t: %s mismatch, expected %0d, actual %0d", $realtime, field, want, got);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

>>> sim/single_rate_three_color_meter_test.sv
// Top-level bench of the single-rate three-color meter: stimulus, handshakes, checking.
module single_rate_three_color_meter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import srtcm_pkg::*;
  import srtcm_meter_check_pkg::*;

  // cycles with no word moving anywhere before the run is declared hung
  localparam int unsigned QUIET_LIMIT   = 4000;
  // margin after the last result is out, before a config write
  localparam int unsigned SETTLE_CYCLES = 8;
  // long receiver hold used to back the meter up into its input
  localparam int unsigned SINK_HOLD     = 80;
  // unused color code, must be marked red in aware mode
  localparam logic [COLOR_W-1:0] COLOR_SPARE = 2'd3;
  localparam logic [RATE_W-1:0]  RATE_1000   = 40'd1000 << RATE_FRAC;
  localparam logic [RATE_W-1:0]  RATE_HALF   = 40'd1 << (RATE_FRAC - 1);

  logic                 clk_i;
  logic                 rst_ni;
  logic                 push;
  logic                 full;
  in_word_t             in_word_i;
  logic                 empty;
  logic                 pop;
  out_word_t            out_word_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  meter_scoreboard   meter_sb = new();
  logic [TIME_W-1:0] arrival_now;
  bit                src_idle_on  = 1'b1;
  bit                sink_idle_on = 1'b1;
  int unsigned       sink_hold    = 0;
  int unsigned       quiet_cycles = 0;

  single_rate_three_color_meter #(
    .RATE_FRAC_BITS(RATE_FRAC)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_word_i  (in_word_i),
    .empty      (empty),
    .pop        (pop),
    .out_word_o (out_word_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Sample every handshake with the values seen just before the edge, so the
  // predictor follows the exact order in which words move.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o)
        meter_sb.write_reg(cfg_reg_e'(cfg_index_i), cfg_data_i);
      if (push && !full)
        meter_sb.note_packet(in_word_i);
      if (pop && !empty)
        meter_sb.check_result(out_word_o);
      if ((cfg_valid_i && cfg_ready_o) || (push && !full) || (pop && !empty))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (rst_ni === 1'b1);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("simulation failed");
    $finish;
  end

  // Result side: pop mostly high, random stall bursts, and one long hold on
  // request from the stimulus process (counted here, in cycles).
  initial begin : result_sink
    pop <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (sink_hold != 0) begin
        pop <= 1'b0;
        repeat (sink_hold) @(posedge clk_i);
        sink_hold = 0;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end else begin
        pop <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  function automatic in_word_t make_packet(logic [TIME_W-1:0] t, logic [BITS_W-1:0] bits,
                                           logic [COLOR_W-1:0] color);
    in_word_t w;
    w.arrival_time = t;
    w.packet_bits  = bits;
    w.in_color     = color;
    return w;
  endfunction

  // Offer one packet word, possibly after a random gap; push stays high
  // when the next word follows right away.
  task automatic send_packet(in_word_t w);
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    push      <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (full);
  endtask

  // Timestamps mostly creep forward; now and then they jump anywhere,
  // which includes going backwards and wrapping.
  task automatic send_random(int unsigned count, int unsigned max_delta, int unsigned max_bits);
    logic [63:0]        wide;
    logic [BITS_W-1:0]  bits;
    int unsigned        pick;
    for (int unsigned n = 0; n < count; n++) begin
      wide = {$urandom(), $urandom()};
      if ($urandom_range(0, 39) == 0)
        arrival_now = wide[TIME_W-1:0];
      else
        arrival_now += $urandom_range(0, max_delta);
      pick = $urandom_range(0, 29);
      if (pick == 0)
        bits = wide[63:44];
      else if (pick == 1)
        bits = '1;
      else if (pick == 2)
        bits = '0;
      else
        bits = BITS_W'($urandom_range(0, max_bits));
      send_packet(make_packet(arrival_now, bits, COLOR_W'($urandom_range(0, 3))));
    end
    push <= 1'b0;
  endtask

  // Hold off until every expected result word is out, then let the
  // pipeline settle.
  task automatic wait_drained();
    @(posedge clk_i);
    while (meter_sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // All four registers, written only with the meter idle. Upper data bits
  // above a register's width carry junk that must be ignored.
  task automatic configure(logic [RATE_W-1:0] rate, logic [TOKEN_W-1:0] cbs,
                           logic [TOKEN_W-1:0] ebs, logic aware);
    logic [7:0] pad;
    wait_drained();
    pad = 8'($urandom_range(0, 255));
    write_reg(REG_CIR_RATE, rate);
    write_reg(REG_CBS, {pad, cbs});
    write_reg(REG_EBS, {~pad, ebs});
    write_reg(REG_COLOR_AWARE, {pad, 31'd0, aware});
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    logic [63:0] wide;
    rst_ni      <= 1'b0;
    push        <= 1'b0;
    in_word_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= REG_CIR_RATE;
    cfg_data_i  <= '0;
    arrival_now = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: 1000 bits/tick, committed 20000, excess 40000, color aware.
    configure(RATE_1000, 32'd20000, 32'd40000, 1'b1);
    send_packet(make_packet(48'd0, 20'd0, COLOR_GREEN));      // first packet, no refill
    send_packet(make_packet(48'd0, 20'd15000, COLOR_GREEN));  // green from committed
    send_packet(make_packet(48'd0, 20'd15000, COLOR_GREEN));  // spills to yellow
    send_packet(make_packet(48'd0, 20'd30000, COLOR_GREEN));  // neither bucket: red
    send_packet(make_packet(48'd0, 20'd100, COLOR_YELLOW));   // yellow-in stays yellow
    send_packet(make_packet(48'd0, 20'd0, COLOR_RED));        // red-in is never charged
    send_packet(make_packet(48'd0, 20'd0, COLOR_SPARE));      // spare code acts as red
    send_packet(make_packet(48'd5, 20'd0, COLOR_YELLOW));     // partial committed refill
    send_packet(make_packet(48'd100, '1, COLOR_GREEN));       // fills both; max length red
    send_packet(make_packet(48'd2, 20'd1, COLOR_GREEN));      // time backwards: huge refill
    send_packet(make_packet('1, 20'd20000, COLOR_YELLOW));    // max timestamp
    send_packet(make_packet(48'd0, 20'd7, COLOR_GREEN));      // wrap forward by one tick
    send_packet(make_packet(48'd3, 20'd10, COLOR_RED));
    push <= 1'b0;
    // color blind: every incoming color counts as green
    configure(RATE_1000, 32'd20000, 32'd40000, 1'b0);
    send_packet(make_packet(48'd4, 20'd5000, COLOR_RED));
    send_packet(make_packet(48'd4, 20'd5000, COLOR_SPARE));
    send_packet(make_packet(48'd4, 20'd15000, COLOR_YELLOW));
    send_packet(make_packet(48'd4, 20'd1000, COLOR_GREEN));
    push <= 1'b0;
    arrival_now = 48'd4;

    // Random packets under a spread of settings, extremes included.
    configure(RATE_1000, 32'd20000, 32'd40000, 1'b1);
    send_random(300, 20, 15000);
    configure(RATE_HALF, 32'd3000, 32'd1000, 1'b0);
    send_random(250, 4000, 2500);
    configure('1, '1, '1, 1'b1);
    send_random(150, 1000000, 1048575);
    configure('0, '0, '0, 1'b0);
    send_random(100, 1000, 3);

    // Back-pressure: hold the result side long enough to fill every queue
    // while packets keep coming, then pause the sender until all is out.
    configure(RATE_1000, 32'd30000, 32'd10000, 1'b1);
    src_idle_on = 1'b0;
    sink_hold   = SINK_HOLD;
    send_random(150, 20, 12000);
    wait_drained();
    src_idle_on = 1'b1;
    send_random(150, 20, 12000);

    repeat (3) begin
      wide = {$urandom(), $urandom()};
      configure(wide[RATE_W-1:0] >> $urandom_range(4, 39), $urandom() >> $urandom_range(0, 31),
                $urandom() >> $urandom_range(0, 31), 1'($urandom_range(0, 1)));
      send_random(150, $urandom_range(1, 5000),
                  $urandom_range(1, 1048575) >> $urandom_range(0, 19));
    end

    // Last stretch at full rate on both sides.
    configure(RATE_1000 >> 2, 32'd8000, 32'd16000, 1'b1);
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    send_random(250, 16, 6000);

    wait_drained();
    if (meter_sb.mismatches == 0 && meter_sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/srtcm_pkg.sv
rtl/srtcm_fifo.sv
rtl/srtcm_front.sv
rtl/srtcm_back.sv
rtl/single_rate_three_color_meter.sv
rtl/srtcm_checker.sv
sim/srtcm_meter_check_pkg.sv
sim/single_rate_three_color_meter_test.sv
